FILE: hw/rtl/deq_pkg.sv
// Package with sizes, codes and transaction types for the double-ended queue.
package deq_pkg;

  // Number of entries and bits per entry.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned WIDTH = 32;

  // Widths derived from the depth.
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Requested action of one transaction.
  typedef enum logic [2:0] {
    ACT_PUSH_TAIL  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_HEAD   = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_READ_AT    = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_e;

  // Error code reported with every result.
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2,
    ERR_RANGE = 2'd3
  } err_e;

  // What one storage cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_e;

  // Input transaction.
  typedef struct packed {
    action_e     action;
    logic [31:0] value;
    logic [3:0]  position;
  } deq_req_t;

  // Result transaction.
  typedef struct packed {
    logic [31:0] data;
    logic [4:0]  count;
    logic        is_empty;
    err_e        error;
  } deq_rsp_t;

  // Status handed from the controller to the top level.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    err_e             error;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } deq_ctl_t;

endpackage

FILE: hw/rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue: a row of shifting cells and a controller.
//
//   Channel   Signals                      Transfer
//   request   start_i, busy_o, req_i       start_i high while busy_o is low
//   result    rsp_valid_o, rsp_o           rsp_valid_o high for one cycle
//
// Each transaction's result appears on the cycle after start_i, and a new
// transaction may be started in every cycle. The rate is set by the cell row,
// which loads, shifts or holds all entries at once. busy_o stays low. Reset
// empties the queue; entry contents are not cleared. The receiver cannot stall,
// so no result is ever held back.
module double_ended_queue_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  deq_pkg::deq_req_t req_i,
  output logic              busy_o,
  output logic              rsp_valid_o,
  output deq_pkg::deq_rsp_t rsp_o
);
  import deq_pkg::*;

  logic [CNT_W-1:0] count_q;
  logic             valid_q;
  deq_rsp_t         rsp_q, rsp_d;
  cell_op_e [DEPTH-1:0] ops;
  deq_ctl_t         ctl;
  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [WIDTH-1:0] rd_data;

  deq_ctrl u_ctrl (
    .start_i (start_i),
    .req_i   (req_i),
    .count_i (count_q),
    .ops_o   (ops),
    .ctl_o   (ctl)
  );

  // Row of cells; each neighbor feeds the next for shifts.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WIDTH-1:0] prev_data;
    logic [WIDTH-1:0] next_data;
    if (k == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_mid_prev
      assign prev_data = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid_next
      assign next_data = cell_data[k+1];
    end
    deq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (ops[k]),
      .value_i (WIDTH'(req_i.value)),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .data_o  (cell_data[k])
    );
  end

  // Read the selected entry before the row updates.
  assign rd_data = ctl.rd_en ? cell_data[ctl.rd_idx] : '0;

  // Build the result of the current transaction.
  always_comb begin
    rsp_d.data     = 32'(rd_data);
    rsp_d.count    = 5'(ctl.count);
    rsp_d.is_empty = (ctl.count == '0);
    rsp_d.error    = ctl.error;
  end

  // Element count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= ctl.count;
      valid_q <= start_i;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o      = 1'b0;
  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: hw/rtl/deq_cell.sv
// One storage cell of the queue; it loads, holds or takes a neighbor's entry.
module deq_cell (
  input  logic                  clk_i,
  input  deq_pkg::cell_op_e     op_i,
  input  logic [deq_pkg::WIDTH-1:0] value_i,
  input  logic [deq_pkg::WIDTH-1:0] prev_i,
  input  logic [deq_pkg::WIDTH-1:0] next_i,
  output logic [deq_pkg::WIDTH-1:0] data_o
);
  import deq_pkg::*;

  logic [WIDTH-1:0] data_q, data_d;

  // Select the next content of the cell.
  always_comb begin
    case (op_i)
      CELL_LOAD:       data_d = value_i;
      CELL_SHIFT_UP:   data_d = prev_i;
      CELL_SHIFT_DOWN: data_d = next_i;
      default:         data_d = data_q;
    endcase
  end

  // Entry register; its content is meaningless until written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: hw/rtl/deq_ctrl.sv
// Controller that decodes an action into cell operations, count and error.
module deq_ctrl (
  input  logic                              start_i,
  input  deq_pkg::deq_req_t                 req_i,
  input  logic [deq_pkg::CNT_W-1:0]         count_i,
  output deq_pkg::cell_op_e [deq_pkg::DEPTH-1:0] ops_o,
  output deq_pkg::deq_ctl_t                 ctl_o
);
  import deq_pkg::*;

  logic full;
  logic empty;
  logic [IDX_W-1:0] back_idx;

  assign full     = (count_i == CNT_W'(DEPTH));
  assign empty    = (count_i == '0);
  assign back_idx = IDX_W'(count_i - CNT_W'(1));

  // Decode the action. Front of the queue always sits in cell zero.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      ops_o[k] = CELL_HOLD;
    end
    ctl_o.count  = count_i;
    ctl_o.error  = ERR_OK;
    ctl_o.rd_en  = 1'b0;
    ctl_o.rd_idx = '0;
    if (start_i) begin
      case (req_i.action)
        ACT_PUSH_TAIL: begin
          if (full) begin
            ctl_o.error = ERR_FULL;
          end else begin
            for (int k = 0; k < DEPTH; k++) begin
              if (count_i == CNT_W'(k)) ops_o[k] = CELL_LOAD;
            end
            ctl_o.count = count_i + CNT_W'(1);
          end
        end
        ACT_PUSH_FRONT: begin
          if (full) begin
            ctl_o.error = ERR_FULL;
          end else begin
            for (int k = 1; k < DEPTH; k++) begin
              ops_o[k] = CELL_SHIFT_UP;
            end
            ops_o[0]    = CELL_LOAD;
            ctl_o.count = count_i + CNT_W'(1);
          end
        end
        ACT_POP_HEAD: begin
          if (empty) begin
            ctl_o.error = ERR_EMPTY;
          end else begin
            for (int k = 0; k < DEPTH; k++) begin
              ops_o[k] = CELL_SHIFT_DOWN;
            end
            ctl_o.rd_en  = 1'b1;
            ctl_o.count  = count_i - CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            ctl_o.error = ERR_EMPTY;
          end else begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_idx = back_idx;
            ctl_o.count  = count_i - CNT_W'(1);
          end
        end
        ACT_PEEK_FRONT: begin
          if (empty) begin
            ctl_o.error = ERR_EMPTY;
          end else begin
            ctl_o.rd_en = 1'b1;
          end
        end
        ACT_PEEK_BACK: begin
          if (empty) begin
            ctl_o.error = ERR_EMPTY;
          end else begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_idx = back_idx;
          end
        end
        ACT_READ_AT: begin
          if (32'(req_i.position) >= 32'(count_i)) begin
            ctl_o.error = ERR_RANGE;
          end else begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_idx = IDX_W'(req_i.position);
          end
        end
        ACT_CLEAR: begin
          ctl_o.count = '0;
        end
        default: begin
          ctl_o.count = count_i;
        end
      endcase
    end
  end

endmodule

FILE: dv/tb_double_ended_queue_unit.sv
// Self-checking testbench for the double-ended queue unit with a built-in scoreboard.
module tb_double_ended_queue_unit;
  import deq_pkg::*;

  // Scoreboard: keeps its own copy of the queue and the expected results.
  class deque_scoreboard;
    logic [WIDTH-1:0] cells [DEPTH];
    int unsigned      front_idx;
    int unsigned      fill;
    deq_rsp_t         expected_rsp_q[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      err_hits [4];
    int unsigned      peak_fill;

    function new();
      front_idx  = 0;
      fill       = 0;
      mismatches = 0;
      checked    = 0;
      peak_fill  = 0;
      foreach (err_hits[i]) err_hits[i] = 0;
    endfunction

    // Applies one action to the queue copy and returns the result it should give.
    function deq_rsp_t apply_action(deq_req_t r);
      deq_rsp_t rsp;
      rsp       = '0;
      rsp.error = ERR_OK;
      case (r.action)
        ACT_PUSH_TAIL: begin
          if (fill >= DEPTH) begin
            rsp.error = ERR_FULL;
          end else begin
            cells[(front_idx + fill) % DEPTH] = r.value[WIDTH-1:0];
            fill++;
          end
        end
        ACT_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            rsp.error = ERR_FULL;
          end else begin
            front_idx        = (front_idx + DEPTH - 1) % DEPTH;
            cells[front_idx] = r.value[WIDTH-1:0];
            fill++;
          end
        end
        ACT_POP_HEAD: begin
          if (fill == 0) begin
            rsp.error = ERR_EMPTY;
          end else begin
            rsp.data  = cells[front_idx];
            front_idx = (front_idx + 1) % DEPTH;
            fill--;
          end
        end
        ACT_POP_BACK: begin
          if (fill == 0) begin
            rsp.error = ERR_EMPTY;
          end else begin
            rsp.data = cells[(front_idx + fill - 1) % DEPTH];
            fill--;
          end
        end
        ACT_PEEK_FRONT: begin
          if (fill == 0) rsp.error = ERR_EMPTY;
          else rsp.data = cells[front_idx];
        end
        ACT_PEEK_BACK: begin
          if (fill == 0) rsp.error = ERR_EMPTY;
          else rsp.data = cells[(front_idx + fill - 1) % DEPTH];
        end
        ACT_READ_AT: begin
          if (r.position >= fill) rsp.error = ERR_RANGE;
          else rsp.data = cells[(front_idx + r.position) % DEPTH];
        end
        ACT_CLEAR: begin
          front_idx = 0;
          fill      = 0;
        end
        default: begin
        end
      endcase
      rsp.count    = 5'(fill);
      rsp.is_empty = (fill == 0);
      return rsp;
    endfunction

    // Notes an accepted transaction and queues the result it must produce.
    function void record_request(deq_req_t r);
      deq_rsp_t rsp;
      rsp = apply_action(r);
      expected_rsp_q = {expected_rsp_q, rsp};
      err_hits[rsp.error]++;
      if (fill > peak_fill) peak_fill = fill;
    endfunction

    // Compares one result from the block with the oldest expected result.
    function void compare_result(deq_rsp_t act);
      deq_rsp_t exp;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result data=%h count=%0d empty=%0b error=%0d",
                 $time, act.data, act.count, act.is_empty, act.error);
        mismatches++;
        return;
      end
      exp = expected_rsp_q[0];
      expected_rsp_q.delete(0);
      checked++;
      if (act.data !== exp.data || act.count !== exp.count ||
          act.is_empty !== exp.is_empty || act.error !== exp.error) begin
        $display("%0t: result mismatch: expected data=%h count=%0d empty=%0b error=%0d",
                 $time, exp.data, exp.count, exp.is_empty, exp.error);
        $display("%0t: result mismatch: actual   data=%h count=%0d empty=%0b error=%0d",
                 $time, act.data, act.count, act.is_empty, act.error);
        mismatches++;
      end
    endfunction
  endclass

  // Random mix of actions, biased to fill, drain or hold the queue level.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  deq_req_t req_i;
  logic     busy_o;
  logic     rsp_valid_o;
  deq_rsp_t rsp_o;

  deque_scoreboard sb;
  int unsigned     issued;
  int unsigned     burst_left;
  bit              hung;

  double_ended_queue_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // Clock with a period of 10.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor: sees pre-edge values, so requests and results are sampled race-free.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.record_request(req_i);
      if (rsp_valid_o) sb.compare_result(rsp_o);
    end
  end

  function automatic deq_req_t make_request(action_e a, logic [31:0] v, logic [3:0] p);
    deq_req_t r;
    r.action   = a;
    r.value    = v;
    r.position = p;
    return r;
  endfunction

  // Draws one random transaction; the mix steers the fill level up or down.
  function automatic deq_req_t pick_request(mix_e mix);
    deq_req_t    r;
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned sel;
    push_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 20 : 40;
    pop_pct  = (mix == MIX_FILL) ? 20 : (mix == MIX_DRAIN) ? 60 : 35;
    roll     = $urandom_range(99);
    if (roll < push_pct) begin
      r.action = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_TAIL;
    end else if (roll < push_pct + pop_pct) begin
      r.action = $urandom_range(1) ? ACT_POP_HEAD : ACT_POP_BACK;
    end else if (roll < 98) begin
      sel = $urandom_range(2);
      r.action = (sel == 0) ? ACT_PEEK_FRONT : (sel == 1) ? ACT_PEEK_BACK : ACT_READ_AT;
    end else begin
      r.action = ACT_CLEAR;
    end
    case ($urandom_range(9))
      0:       r.value = '0;
      1:       r.value = '1;
      default: r.value = $urandom;
    endcase
    // Indexed reads mostly land inside the valid range.
    if (sb.fill > 0 && $urandom_range(3) != 0) r.position = 4'($urandom_range(sb.fill - 1));
    else r.position = 4'($urandom_range(15));
    return r;
  endfunction

  // Sends one transaction in bursts with random gaps, then waits for acceptance.
  task automatic issue(input deq_req_t r);
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    issued++;
  endtask

  // Holds off new transactions until every expected result has arrived.
  task automatic wait_for_results();
    int unsigned guard;
    guard   = 0;
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (sb.expected_rsp_q.size() != 0 && guard < 1000);
    if (sb.expected_rsp_q.size() != 0) hung = 1'b1;
  endtask

  // Empty-queue errors, filling to capacity, full errors, edge reads, pops and a clear.
  task automatic run_directed();
    logic [31:0] v;
    issue(make_request(ACT_POP_HEAD, '0, '0));
    issue(make_request(ACT_POP_BACK, '0, '0));
    issue(make_request(ACT_PEEK_FRONT, '0, '0));
    issue(make_request(ACT_PEEK_BACK, '0, '0));
    issue(make_request(ACT_READ_AT, '0, 4'hF));
    issue(make_request(ACT_CLEAR, '0, '0));
    for (int i = 0; i < DEPTH; i++) begin
      v = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : (i == 2) ? 32'hAAAA_AAAA :
          (i == 3) ? 32'h5555_5555 : $urandom;
      issue(make_request((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_TAIL, v, '0));
    end
    issue(make_request(ACT_PUSH_TAIL, 32'h1234_5678, '0));
    issue(make_request(ACT_PUSH_FRONT, 32'h8765_4321, '0));
    issue(make_request(ACT_READ_AT, '0, 4'hF));
    issue(make_request(ACT_PEEK_FRONT, '0, '0));
    issue(make_request(ACT_PEEK_BACK, '0, '0));
    issue(make_request(ACT_POP_HEAD, '0, '0));
    issue(make_request(ACT_POP_BACK, '0, '0));
    issue(make_request(ACT_READ_AT, '0, 4'hE));
    issue(make_request(ACT_CLEAR, '0, '0));
  endtask

  // Main sequence: reset, directed part, random part, drain and verdict.
  initial begin
    mix_e        mix;
    int unsigned mix_left;
    start_i    <= 1'b0;
    req_i      <= '0;
    rst_ni     <= 1'b0;
    sb         = new();
    issued     = 0;
    burst_left = 0;
    hung       = 1'b0;
    mix        = MIX_EVEN;
    mix_left   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    wait_for_results();

    for (int n = 0; n < 1700; n++) begin
      if (mix_left == 0) begin
        mix      = mix_e'($urandom_range(2));
        mix_left = $urandom_range(20, 80);
      end
      mix_left--;
      issue(pick_request(mix));
      if (n % 500 == 499) wait_for_results();
    end

    wait_for_results();
    repeat (3) @(posedge clk_i);
    if (sb.expected_rsp_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.expected_rsp_q.size());
    $display("Ran %0d transactions of every action kind; peak fill %0d of %0d.",
             issued, sb.peak_fill, DEPTH);
    $display("Rejections seen: %0d full, %0d empty, %0d out of range; %0d results checked.",
             sb.err_hits[ERR_FULL], sb.err_hits[ERR_EMPTY], sb.err_hits[ERR_RANGE],
             sb.checked);
    if (sb.mismatches == 0 && sb.expected_rsp_q.size() == 0 && !hung) begin
      $display("tb_double_ended_queue_unit: PASS");
    end else begin
      $display("tb_double_ended_queue_unit: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2000000;
    $display("tb_double_ended_queue_unit: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_unit.sv
dv/tb_double_ended_queue_unit.sv
